// File: rtl/access_pattern_detector_unit_defines.svh
// Assertion macros for the access pattern detector
`ifndef ACCESS_PATTERN_DETECTOR_UNIT_DEFINES_SVH
`define ACCESS_PATTERN_DETECTOR_UNIT_DEFINES_SVH

// a implies b on the same edge
`define APD_ASSERT_IMPL(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("apd check failed");

// a implies b on the next edge
`define APD_ASSERT_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("apd check failed");

`endif

// File: rtl/apd_pkg.sv
`timescale 1ns / 1ps
package apd_pkg;

  localparam int AW = 48;
  localparam int GW = 49;
  localparam int CW = 32;
  localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

  typedef enum logic [1:0] {
    PT_FIX        = 2'd0,
    PT_SEQ        = 2'd1,
    PT_STRIDE     = 2'd2,
    PT_SEQ_STRIDE = 2'd3
  } pat_type_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_LOOKUP = 2'd1,
    ST_UPDATE = 2'd2
  } apd_state_t;

  // one table entry
  typedef struct packed {
    logic          is_write;
    logic [7:0]    access_size;
    logic [AW-1:0] instr_addr;
    logic [GW-1:0] last_gap;
    logic [AW-1:0] last_start;
    logic [AW-1:0] last_end;
    logic [AW-1:0] cand_base;
    logic [GW-1:0] cand_offset;
    logic [AW-1:0] cand_size;
    logic [GW-1:0] cand_gap;
    logic [CW-1:0] cand_stride;
    logic [CW-1:0] cand_repeat;
    logic [AW-1:0] latest_base;
    logic [GW-1:0] latest_offset;
    logic [AW-1:0] latest_size;
    logic [GW-1:0] latest_gap;
    logic [CW-1:0] latest_stride;
    logic [CW-1:0] latest_repeat;
    logic [1:0]    latest_type;
    logic [CW-1:0] started;
  } apd_entry_t;

  typedef struct packed {
    logic capture;  // latch input word, start set read
    logic update;   // evaluate set, write matching or free entry, load result
  } apd_cmd_t;

  function automatic logic [CW-1:0] bump32(input logic [CW-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

endpackage

// File: rtl/access_pattern_detector_unit.sv
`timescale 1ns / 1ps
// An accepted word is latched with its set read; the set is then evaluated, a
// matching or free entry written and the result word registered. No new word is
// taken until then; set read then entry write on one memory row. A stalled result
// holds the table update loop until it is taken. Reset (rst_n low, synchronous)
// clears all entry valid bits and the control state; the table is then usable.
`include "access_pattern_detector_unit_defines.svh"
module access_pattern_detector_unit
  import apd_pkg::*;
#(
  parameter int SETS = 64,
  parameter int WAYS = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_is_write,
  input  logic [7:0]           in_access_size,
  input  logic [AW-1:0]        in_instr_addr,
  input  logic [AW-1:0]        in_data_addr,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_entry_slot,
  output logic                 out_entry_hit,
  output logic                 out_set_full,
  output logic                 out_new_pattern,
  output logic signed [GW-1:0] out_pat_offset,
  output logic [AW-1:0]        out_pat_size,
  output logic signed [GW-1:0] out_pat_data_offset,
  output logic [CW-1:0]        out_pat_stride_count,
  output logic [CW-1:0]        out_pat_repeat,
  output logic [1:0]           out_pat_type,
  output logic [CW-1:0]        out_pattern_count
);

  apd_cmd_t cmd;
  logic     out_busy;

  apd_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_busy(out_busy), .cmd(cmd)
  );

  apd_dpath #(.SETS(SETS), .WAYS(WAYS)) u_dpath (
    .clk(clk), .rst_n(rst_n), .cmd(cmd),
    .in_is_write(in_is_write), .in_access_size(in_access_size),
    .in_instr_addr(in_instr_addr), .in_data_addr(in_data_addr),
    .out_stall(out_stall), .out_valid(out_valid), .out_busy(out_busy),
    .out_entry_slot(out_entry_slot), .out_entry_hit(out_entry_hit),
    .out_set_full(out_set_full), .out_new_pattern(out_new_pattern),
    .out_pat_offset(out_pat_offset), .out_pat_size(out_pat_size),
    .out_pat_data_offset(out_pat_data_offset),
    .out_pat_stride_count(out_pat_stride_count), .out_pat_repeat(out_pat_repeat),
    .out_pat_type(out_pat_type), .out_pattern_count(out_pattern_count)
  );

  `APD_ASSERT_IMPL(a_full_no_hit, out_valid && out_set_full, !out_entry_hit && !out_new_pattern)
  `APD_ASSERT_IMPL(a_one_cmd, cmd.capture, !cmd.update)
  `APD_ASSERT_NEXT(a_update_valid, cmd.update, out_valid)
  `APD_ASSERT_NEXT(a_capture_stalls, cmd.capture, in_stall)

endmodule

// File: rtl/apd_ctrl.sv
`timescale 1ns / 1ps
module apd_ctrl
  import apd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  logic     out_busy,
  output apd_cmd_t cmd
);

  apd_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_LOOKUP;
      ST_LOOKUP: if (!out_busy) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall    = 1'b1;
    cmd.capture = 1'b0;
    cmd.update  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      ST_LOOKUP: cmd.update = !out_busy;
      default: ;
    endcase
  end

endmodule

// File: rtl/apd_dpath.sv
`timescale 1ns / 1ps
module apd_dpath
  import apd_pkg::*;
#(
  parameter int SETS = 64,
  parameter int WAYS = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  apd_cmd_t             cmd,
  input  logic                 in_is_write,
  input  logic [7:0]           in_access_size,
  input  logic [AW-1:0]        in_instr_addr,
  input  logic [AW-1:0]        in_data_addr,
  input  logic                 out_stall,
  output logic                 out_valid,
  output logic                 out_busy,
  output logic [7:0]           out_entry_slot,
  output logic                 out_entry_hit,
  output logic                 out_set_full,
  output logic                 out_new_pattern,
  output logic signed [GW-1:0] out_pat_offset,
  output logic [AW-1:0]        out_pat_size,
  output logic signed [GW-1:0] out_pat_data_offset,
  output logic [CW-1:0]        out_pat_stride_count,
  output logic [CW-1:0]        out_pat_repeat,
  output logic [1:0]           out_pat_type,
  output logic [CW-1:0]        out_pattern_count
);

  localparam int SLOTS = SETS * WAYS;
  localparam int SW    = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int KW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SUMW  = AW + 2;

  // one memory row is a whole set
  apd_entry_t            mem [SETS][WAYS];
  logic [SLOTS-1:0]      valid_r;
  apd_entry_t            rd_r [WAYS];
  logic [SW-1:0]         set_r;
  logic                  rw_r;
  logic [7:0]            sz_r;
  logic [AW-1:0]         ia_r, da_r;

  logic [SUMW-1:0]       key_sum;
  logic [SW-1:0]         set_idx;

  assign key_sum = SUMW'(in_is_write) + SUMW'(in_access_size) + SUMW'(in_instr_addr);
  assign set_idx = SW'(key_sum % SUMW'(SETS));

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      set_r <= set_idx;
      rw_r  <= in_is_write;
      sz_r  <= in_access_size;
      ia_r  <= in_instr_addr;
      da_r  <= in_data_addr;
      for (int w = 0; w < WAYS; w++) rd_r[w] <= mem[set_idx][w];
    end
  end

  // way match and free search
  logic          hit, have_free;
  logic [WW-1:0] hit_way, free_way, sel_way;
  logic [KW-1:0] first_slot;

  assign first_slot = KW'(set_r) * KW'(WAYS);

  always_comb begin
    hit = 1'b0; have_free = 1'b0; hit_way = '0; free_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (valid_r[first_slot + KW'(w)]) begin
        if (!hit && rd_r[w].instr_addr == ia_r && rd_r[w].is_write == rw_r &&
            rd_r[w].access_size == sz_r) begin
          hit = 1'b1; hit_way = WW'(w);
        end
      end else if (!have_free) begin
        have_free = 1'b1; free_way = WW'(w);
      end
    end
    sel_way = hit ? hit_way : free_way;
  end

  apd_entry_t    e, n;
  logic          newp;
  logic [AW-1:0] end_a, csize;
  logic [GW-1:0] gap;
  logic          cml;

  assign end_a = da_r + AW'(sz_r);

  always_comb begin
    e     = rd_r[sel_way];
    n     = e;
    newp  = 1'b0;
    gap   = {1'b0, da_r} - {1'b0, e.last_end};
    csize = e.last_end - e.last_start;
    cml   = ((e.latest_base == e.cand_base && e.latest_size == e.cand_size) &&
             (e.latest_stride == '0 ||
              (e.latest_gap == e.cand_gap && e.latest_stride == e.cand_stride))) ||
            (e.latest_offset == e.cand_offset && e.latest_size == e.cand_size &&
             e.latest_gap == e.cand_gap && e.latest_stride == e.cand_stride);
    if (!hit) begin
      n             = '0;
      n.is_write    = rw_r;
      n.access_size = sz_r;
      n.instr_addr  = ia_r;
      n.last_start  = da_r;
      n.last_end    = end_a;
    end else if (da_r == e.last_end) begin
      n.last_end = end_a;
    end else begin
      if (e.last_gap == e.cand_gap && csize == e.cand_size) begin
        if (e.cand_base == e.last_start) n.cand_repeat = bump32(e.cand_repeat);
        else                             n.cand_stride = bump32(e.cand_stride);
      end else begin
        if (e.cand_size == '0 || cml) begin
          n.latest_repeat = bump32(e.latest_repeat);
        end else begin
          newp            = 1'b1;
          n.latest_base   = e.cand_base;
          n.latest_offset = e.cand_offset;
          n.latest_size   = e.cand_size;
          n.latest_gap    = e.cand_gap;
          n.latest_stride = e.cand_stride;
          n.latest_repeat = e.cand_repeat;
          if (AW'(e.access_size) == e.cand_size && e.cand_stride == '0)
            n.latest_type = PT_FIX;
          else if (AW'(e.access_size) < e.cand_size && e.cand_stride == '0)
            n.latest_type = PT_SEQ;
          else if (AW'(e.access_size) == e.cand_size)
            n.latest_type = PT_STRIDE;
          else
            n.latest_type = PT_SEQ_STRIDE;
          n.started = bump32(e.started);
        end
        n.cand_base   = e.last_start;
        n.cand_offset = e.last_gap;
        n.cand_size   = csize;
        n.cand_gap    = gap;
        n.cand_stride = '0;
        n.cand_repeat = CW'(1);
      end
      n.last_gap   = gap;
      n.last_start = da_r;
      n.last_end   = end_a;
    end
  end

  logic do_wr;
  assign do_wr = cmd.update && (hit || have_free);

  always_ff @(posedge clk) begin
    if (do_wr) mem[set_r][sel_way] <= n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (do_wr) begin
      valid_r[first_slot + KW'(sel_way)] <= 1'b1;
    end
  end

  logic out_valid_r;
  assign out_valid = out_valid_r;
  assign out_busy  = out_valid_r && out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.update) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_entry_hit <= hit;
      if (!hit && !have_free) begin
        out_entry_slot       <= 8'(first_slot);
        out_set_full         <= 1'b1;
        out_new_pattern      <= 1'b0;
        out_pat_offset       <= '0;
        out_pat_size         <= '0;
        out_pat_data_offset  <= '0;
        out_pat_stride_count <= '0;
        out_pat_repeat       <= '0;
        out_pat_type         <= '0;
        out_pattern_count    <= '0;
      end else begin
        out_entry_slot       <= 8'(first_slot + KW'(sel_way));
        out_set_full         <= 1'b0;
        out_new_pattern      <= newp;
        out_pat_offset       <= n.latest_offset;
        out_pat_size         <= n.latest_size;
        out_pat_data_offset  <= n.latest_gap;
        out_pat_stride_count <= n.latest_stride;
        out_pat_repeat       <= n.latest_repeat;
        out_pat_type         <= n.latest_type;
        out_pattern_count    <= n.started;
      end
    end
  end

endmodule

// File: tb/access_pattern_detector_unit_tb.sv
`timescale 1ns / 1ps
module access_pattern_detector_unit_tb;
  import apd_pkg::*;

  localparam int NSETS = 64;
  localparam int NWAYS = 4;
  localparam int NSLOTS = NSETS * NWAYS;
  localparam int CYCLE_LIMIT = 400000;
  localparam int POOL_N = 24;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_is_write = 1'b0;
  logic [7:0] in_access_size = 8'd1;
  logic [AW-1:0] in_instr_addr = '0;
  logic [AW-1:0] in_data_addr = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_entry_slot;
  logic out_entry_hit;
  logic out_set_full;
  logic out_new_pattern;
  logic signed [GW-1:0] out_pat_offset;
  logic [AW-1:0] out_pat_size;
  logic signed [GW-1:0] out_pat_data_offset;
  logic [CW-1:0] out_pat_stride_count;
  logic [CW-1:0] out_pat_repeat;
  logic [1:0] out_pat_type;
  logic [CW-1:0] out_pattern_count;

  access_pattern_detector_unit #(.SETS(NSETS), .WAYS(NWAYS)) u_dut (.*);

  always #5 clk = ~clk;

  // per-instruction tracking record
  typedef struct {
    logic          rw;
    logic [7:0]    sz;
    logic [AW-1:0] ia;
    logic [GW-1:0] run_gap;
    logic [AW-1:0] run_start;
    logic [AW-1:0] run_end;
    logic [AW-1:0] c_base;
    logic [GW-1:0] c_off;
    logic [AW-1:0] c_size;
    logic [GW-1:0] c_gap;
    logic [CW-1:0] c_stride;
    logic [CW-1:0] c_rep;
    logic [AW-1:0] p_base;
    logic [GW-1:0] p_off;
    logic [AW-1:0] p_size;
    logic [GW-1:0] p_gap;
    logic [CW-1:0] p_stride;
    logic [CW-1:0] p_rep;
    pat_type_t     p_type;
    logic [CW-1:0] p_count;
  } track_t;

  typedef struct {
    logic [7:0]    slot;
    logic          hit;
    logic          full;
    logic          newp;
    logic [GW-1:0] off;
    logic [AW-1:0] size;
    logic [GW-1:0] gap;
    logic [CW-1:0] stride;
    logic [CW-1:0] rep;
    logic [1:0]    ptype;
    logic [CW-1:0] count;
  } pattern_word_t;

  track_t tracks[NSLOTS];
  bit slot_used[NSLOTS];
  pattern_word_t pending_q[$];

  int errors = 0;
  int cycles = 0;
  int items_sent = 0;
  int words_checked = 0;
  int n_new = 0;
  int n_full = 0;
  bit no_idle = 1'b0;

  logic [AW-1:0] key_pool[POOL_N];
  logic [7:0] size_pool[POOL_N];
  logic rw_pool[POOL_N];

  function automatic logic [CW-1:0] sat_inc(logic [CW-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic bit cand_same_as_latest(int s);
    if (tracks[s].p_base == tracks[s].c_base && tracks[s].p_size == tracks[s].c_size) begin
      if (tracks[s].p_stride == 0) return 1'b1;
      if (tracks[s].p_gap == tracks[s].c_gap && tracks[s].p_stride == tracks[s].c_stride)
        return 1'b1;
    end
    return tracks[s].p_off == tracks[s].c_off && tracks[s].p_size == tracks[s].c_size &&
           tracks[s].p_gap == tracks[s].c_gap && tracks[s].p_stride == tracks[s].c_stride;
  endfunction

  function automatic pattern_word_t predict_access(logic rw, logic [7:0] sz,
                                                   logic [AW-1:0] ia, logic [AW-1:0] da);
    pattern_word_t r;
    logic [AW+1:0] key_sum;
    logic [AW-1:0] end_addr;
    logic [GW-1:0] gap;
    logic [AW-1:0] csize;
    int first, s, free_slot;
    bit hit, have_free;
    r = '{default: '0};
    end_addr = da + sz;
    key_sum = rw + sz + ia;
    first = key_sum[5:0] * NWAYS;
    hit = 0;
    have_free = 0;
    s = 0;
    free_slot = 0;
    for (int w = 0; w < NWAYS; w++) begin
      if (slot_used[first + w]) begin
        if (!hit && tracks[first + w].ia == ia && tracks[first + w].rw == rw &&
            tracks[first + w].sz == sz) begin
          hit = 1;
          s = first + w;
        end
      end else if (!have_free) begin
        have_free = 1;
        free_slot = first + w;
      end
    end
    if (!hit && !have_free) begin
      r.slot = first[7:0];
      r.full = 1'b1;
      return r;
    end
    if (!hit) begin
      s = free_slot;
      slot_used[s] = 1'b1;
      tracks[s] = '{rw: rw, sz: sz, ia: ia, run_start: da, run_end: end_addr,
                    p_type: PT_FIX, default: '0};
    end else if (da == tracks[s].run_end) begin
      tracks[s].run_end = end_addr;
    end else begin
      gap = {1'b0, da} - {1'b0, tracks[s].run_end};
      csize = tracks[s].run_end - tracks[s].run_start;
      if (tracks[s].run_gap == tracks[s].c_gap && csize == tracks[s].c_size) begin
        if (tracks[s].c_base == tracks[s].run_start)
          tracks[s].c_rep = sat_inc(tracks[s].c_rep);
        else
          tracks[s].c_stride = sat_inc(tracks[s].c_stride);
      end else begin
        if (tracks[s].c_size == 0 || cand_same_as_latest(s)) begin
          tracks[s].p_rep = sat_inc(tracks[s].p_rep);
        end else begin
          tracks[s].p_base = tracks[s].c_base;
          tracks[s].p_off = tracks[s].c_off;
          tracks[s].p_size = tracks[s].c_size;
          tracks[s].p_gap = tracks[s].c_gap;
          tracks[s].p_stride = tracks[s].c_stride;
          tracks[s].p_rep = tracks[s].c_rep;
          if ({40'd0, sz} == tracks[s].c_size && tracks[s].c_stride == 0)
            tracks[s].p_type = PT_FIX;
          else if ({40'd0, sz} < tracks[s].c_size && tracks[s].c_stride == 0)
            tracks[s].p_type = PT_SEQ;
          else if ({40'd0, sz} == tracks[s].c_size)
            tracks[s].p_type = PT_STRIDE;
          else
            tracks[s].p_type = PT_SEQ_STRIDE;
          tracks[s].p_count = sat_inc(tracks[s].p_count);
          r.newp = 1'b1;
        end
        tracks[s].c_base = tracks[s].run_start;
        tracks[s].c_off = tracks[s].run_gap;
        tracks[s].c_size = csize;
        tracks[s].c_gap = gap;
        tracks[s].c_stride = '0;
        tracks[s].c_rep = 32'd1;
      end
      tracks[s].run_gap = gap;
      tracks[s].run_start = da;
      tracks[s].run_end = end_addr;
    end
    r.slot = s[7:0];
    r.hit = hit;
    r.off = tracks[s].p_off;
    r.size = tracks[s].p_size;
    r.gap = tracks[s].p_gap;
    r.stride = tracks[s].p_stride;
    r.rep = tracks[s].p_rep;
    r.ptype = tracks[s].p_type;
    r.count = tracks[s].p_count;
    return r;
  endfunction

  function automatic int draw_wait();
    return no_idle ? 0 : $urandom_range(0, 7);
  endfunction

  task automatic send_access(logic rw, logic [7:0] sz, logic [AW-1:0] ia, logic [AW-1:0] da);
    pattern_word_t exp_word;
    int gap_cycles;
    bit stalled;
    gap_cycles = draw_wait();
    if (gap_cycles > 0) begin
      in_valid <= 1'b0;
      repeat (gap_cycles) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_is_write <= rw;
    in_access_size <= sz;
    in_instr_addr <= ia;
    in_data_addr <= da;
    exp_word = predict_access(rw, sz, ia, da);
    // stall is sampled mid-cycle, ahead of the edge that may accept
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    pending_q.push_back(exp_word);
    items_sent++;
    n_new += exp_word.newp;
    n_full += exp_word.full;
  endtask

  // chunks of chunk_len contiguous words, chunk_gap bytes between chunks
  task automatic send_stream(logic rw, logic [7:0] sz, logic [AW-1:0] ia, logic [AW-1:0] base,
                             int chunk_len, logic [AW-1:0] chunk_gap, int n_chunks);
    logic [AW-1:0] cur;
    cur = base;
    for (int c = 0; c < n_chunks; c++) begin
      for (int k = 0; k < chunk_len; k++) begin
        send_access(rw, sz, ia, cur);
        cur = cur + sz;
      end
      cur = cur + chunk_gap;
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_q.size() != 0);
  endtask

  task automatic test_extremes();
    send_access(1'b0, 8'd1, '0, '0);
    send_access(1'b0, 8'd1, '0, 48'd1);                // extends chunk
    send_access(1'b1, 8'd255, '1, '1);                 // chunk end wraps
    send_access(1'b1, 8'd255, '1, 48'd254);            // extend across wrap
    send_access(1'b1, 8'd255, '1, 48'h8000_0000_0000); // large positive gap
    send_access(1'b1, 8'd255, '1, 48'd5);              // negative gap
    send_access(1'b0, 8'd170, 48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555);
    send_access(1'b1, 8'd85, 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA);
  endtask

  task automatic test_pattern_types();
    // fixed repeat, then move to stride, then sequential stride
    send_stream(1'b0, 8'd8, 48'h40_1000, 48'h2000, 1, -48'sd8, 3);
    send_stream(1'b0, 8'd8, 48'h40_1000, 48'h3000, 1, 48'd24, 4);
    send_stream(1'b0, 8'd8, 48'h40_1000, 48'h9000, 3, 48'd40, 3);
  endtask

  task automatic test_full_set();
    // six keys that all land in set 1
    for (int k = 0; k < 5; k++)
      send_access(1'b0, 8'd1, 48'(64 * k), 48'h100 * k);
    send_access(1'b1, 8'd1, 48'd63, 48'h700);
    send_access(1'b0, 8'd1, 48'd64, 48'h101);          // tracked key still hits
  endtask

  task automatic test_random();
    int pick, chunk_len, n_chunks;
    logic [AW-1:0] gap;
    for (int i = 0; i < POOL_N; i++) begin
      key_pool[i] = AW'({$urandom, $urandom});
      size_pool[i] = (i % 3 == 0) ? 8'(1 << $urandom_range(0, 7)) : 8'($urandom_range(1, 255));
      rw_pool[i] = 1'($urandom_range(0, 1));
    end
    while (items_sent < 1550) begin
      if (($urandom_range(0, 149) == 0)) no_idle = ~no_idle;
      pick = $urandom_range(0, POOL_N - 1);
      if ($urandom_range(0, 4) == 0) begin
        if ($urandom_range(0, 1))
          send_access(1'($urandom_range(0, 1)), 8'($urandom_range(1, 255)),
                      AW'({$urandom, $urandom}), AW'({$urandom, $urandom}));
        else
          send_access(rw_pool[pick], size_pool[pick], key_pool[pick],
                      AW'({$urandom, $urandom}));
      end else begin
        chunk_len = $urandom_range(1, 4);
        n_chunks = $urandom_range(2, 10);
        case ($urandom_range(0, 3))
          0: gap = -(48'(chunk_len) * size_pool[pick]);  // same chunk again
          1: gap = 48'($urandom_range(1, 64));
          2: gap = -48'($urandom_range(1, 600));
          default: gap = AW'({$urandom, $urandom});
        endcase
        send_stream(rw_pool[pick], size_pool[pick], key_pool[pick],
                    AW'({$urandom, $urandom}), chunk_len, gap, n_chunks);
      end
      if (items_sent > 700 && items_sent < 760) drain_results();
    end
  endtask

  // result side: random stall per word, compare with oldest expectation
  initial begin
    pattern_word_t e;
    int n;
    bit seen;
    forever begin
      n = draw_wait();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      // valid and fields sampled mid-cycle; the following edge takes the word
      do begin
        @(negedge clk);
        seen = (out_valid === 1'b1);
        if (!seen) @(posedge clk);
      end while (!seen);
      words_checked++;
      if (pending_q.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        e = pending_q.pop_front();
        if (out_entry_slot !== e.slot) begin
          $error("entry_slot exp %0d got %0d", e.slot, out_entry_slot); errors++;
        end
        if (out_entry_hit !== e.hit) begin
          $error("entry_hit exp %0d got %0d", e.hit, out_entry_hit); errors++;
        end
        if (out_set_full !== e.full) begin
          $error("set_full exp %0d got %0d", e.full, out_set_full); errors++;
        end
        if (out_new_pattern !== e.newp) begin
          $error("new_pattern exp %0d got %0d", e.newp, out_new_pattern); errors++;
        end
        if (out_pat_offset !== e.off) begin
          $error("pat_offset exp %h got %h", e.off, out_pat_offset); errors++;
        end
        if (out_pat_size !== e.size) begin
          $error("pat_size exp %h got %h", e.size, out_pat_size); errors++;
        end
        if (out_pat_data_offset !== e.gap) begin
          $error("pat_data_offset exp %h got %h", e.gap, out_pat_data_offset); errors++;
        end
        if (out_pat_stride_count !== e.stride) begin
          $error("pat_stride_count exp %0d got %0d", e.stride, out_pat_stride_count); errors++;
        end
        if (out_pat_repeat !== e.rep) begin
          $error("pat_repeat exp %0d got %0d", e.rep, out_pat_repeat); errors++;
        end
        if (out_pat_type !== e.ptype) begin
          $error("pat_type exp %0d got %0d", e.ptype, out_pat_type); errors++;
        end
        if (out_pattern_count !== e.count) begin
          $error("pattern_count exp %0d got %0d", e.count, out_pattern_count); errors++;
        end
      end
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_extremes();
    test_pattern_types();
    test_full_set();
    test_random();
    drain_results();
    repeat (10) @(posedge clk);
    $display("covered %0d accesses, %0d result words checked", items_sent, words_checked);
    $display("%0d pattern replacements, %0d accesses dropped on a full set", n_new, n_full);
    if (errors == 0 && pending_q.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
